@@ rtl/ohtab_pkg.sv @@
// ----------------------------------------------------------------------------
// Open-addressing hash table package
// Field widths, command and status codes, register indexes and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ohtab_pkg;

  // Default table depth.
  localparam int SLOTS_DEF = 1024;

  // Payload field widths.
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 31;
  localparam int SLOT_W   = 10;
  localparam int STATUS_W = 2;

  // Configuration register widths and reset values.
  localparam int SIZE_W     = 4;
  localparam int STEP_W     = 10;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 1;

  localparam logic [SIZE_W-1:0] SIZE_RST = 4'd10;
  localparam logic [STEP_W-1:0] STEP_RST = 10'd1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_STEP = 1'b1;

  // Command codes; the fourth code is unknown and answers not found.
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ENTER = 2'd1,
    CMD_FIND  = 2'd2
  } cmd_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_PRESENT  = 2'd0,
    STAT_NEW      = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic    accept;      // latch the key, start at the home slot
    logic    adv;         // move to the next probe slot
    logic    ins;         // write key and used bit at the current slot
    logic    clr_we;      // clear the used bit at the sweep address
    logic    res_load;    // capture a result
    status_e res_status;  // status of the captured result
    logic    res_use_slot;// result carries the current slot, else zero
    logic    out_load;    // move the result into the output register
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic used;      // probed slot holds a key
    logic hit;       // probed slot holds the key searched for
    logic last;      // this is the final allowed probe
    logic clr_last;  // sweep is at the last slot
  } dp_stat_t;

endpackage

@@ rtl/ohtab_in_if.sv @@
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one command and key per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ohtab_in_if;
  import ohtab_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink   (input valid, input cmd, input key, output ready);

endinterface

@@ rtl/ohtab_out_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one slot and status per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ohtab_out_if;
  import ohtab_pkg::*;

  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output slot, output status, input ready);
  modport sink   (input valid, input slot, input status, output ready);

endinterface

@@ rtl/ohtab_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ohtab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ohtab_ctrl.sv @@
// ----------------------------------------------------------------------------
// Hash table controller
// Sequences the clearing sweep, the probe loop and the result handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ohtab_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [ohtab_pkg::CMD_W-1:0] in_cmd_i,
  output logic                        in_ready_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  input  ohtab_pkg::dp_stat_t         stat_i,
  output ohtab_pkg::dp_cmd_t          cmd_o
);
  import ohtab_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_RESP
  } state_e;

  state_e  state_q, state_d;
  logic    clr_cmd_q, clr_cmd_d;
  logic    enter_q, enter_d;
  logic    out_valid_q, out_valid_d;
  dp_cmd_t cmd;
  logic    out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state and datapath commands.
  always_comb begin
    state_d   = state_q;
    clr_cmd_d = clr_cmd_q;
    enter_d   = enter_q;
    cmd       = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (stat_i.clr_last) begin
          clr_cmd_d = 1'b0;
          if (clr_cmd_q) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = STAT_NEW;
            state_d        = ST_RESP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          unique case (in_cmd_i)
            CMD_CLEAR: begin
              clr_cmd_d = 1'b1;
              state_d   = ST_CLEAR;
            end
            CMD_ENTER: begin
              enter_d = 1'b1;
              state_d = ST_PROBE;
            end
            CMD_FIND: begin
              enter_d = 1'b0;
              state_d = ST_PROBE;
            end
            default: begin
              cmd.res_load   = 1'b1;
              cmd.res_status = STAT_NOTFOUND;
              state_d        = ST_RESP;
            end
          endcase
        end
      end
      ST_PROBE: begin
        // One slot is checked per cycle while the next one is read.
        if (!stat_i.used) begin
          cmd.res_load = 1'b1;
          if (enter_q) begin
            cmd.ins          = 1'b1;
            cmd.res_status   = STAT_NEW;
            cmd.res_use_slot = 1'b1;
          end else begin
            cmd.res_status = STAT_NOTFOUND;
          end
          state_d = ST_RESP;
        end else if (stat_i.hit) begin
          cmd.res_load     = 1'b1;
          cmd.res_status   = STAT_PRESENT;
          cmd.res_use_slot = 1'b1;
          state_d          = ST_RESP;
        end else if (stat_i.last) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = STAT_FULL;
          state_d        = ST_RESP;
        end else begin
          cmd.adv = 1'b1;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = cmd.out_load || (out_valid_q && !out_ready_i);
  end

  // State and registered outputs; reset starts with the clearing sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cmd_q   <= 1'b0;
      enter_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cmd_q   <= clr_cmd_d;
      enter_q     <= enter_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

@@ rtl/ohtab_dp.sv @@
// ----------------------------------------------------------------------------
// Hash table datapath
// Configuration registers, probe address and count, key and used-bit
// memories, clearing sweep counter and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ohtab_dp #(
  parameter int SLOTS = ohtab_pkg::SLOTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ohtab_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ohtab_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [ohtab_pkg::KEY_W-1:0]      in_key_i,
  input  ohtab_pkg::dp_cmd_t               cmd_i,
  output ohtab_pkg::dp_stat_t              stat_o,
  output logic [ohtab_pkg::SLOT_W-1:0]     out_slot_o,
  output logic [ohtab_pkg::STATUS_W-1:0]   out_status_o
);
  import ohtab_pkg::*;

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int LG_MAX = $clog2(SLOTS + 1) - 1;
  localparam logic [SIZE_W:0]  LG_MAX_V = (SIZE_W + 1)'(LG_MAX);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

  logic [SIZE_W-1:0]   size_q;
  logic [STEP_W-1:0]   step_q;
  logic [KEY_W-1:0]    key_q;
  logic [IDX_W-1:0]    k_q, k_d;
  logic [IDX_W-1:0]    cnt_q, cnt_d;
  logic [IDX_W-1:0]    clr_addr_q, clr_addr_d;
  logic [SLOT_W-1:0]   res_slot_q, out_slot_q;
  logic [STATUS_W-1:0] res_status_q, out_status_q;

  logic [SIZE_W:0]     lg_eff;
  logic [IDX_W:0]      pow, pow_m1;
  logic [IDX_W-1:0]    mask, step_x, home_in, k_next, rd_addr;
  logic [KEY_W-1:0]    key_rd;
  logic                used_rd;
  logic                used_we, used_wd;
  logic [IDX_W-1:0]    used_waddr;

  // Table mask, with the size limited to what the memory holds.
  always_comb begin
    lg_eff = ({1'b0, size_q} > LG_MAX_V) ? LG_MAX_V : {1'b0, size_q};
    pow    = (IDX_W + 1)'(1) << lg_eff;
    pow_m1 = pow - (IDX_W + 1)'(1);
    mask   = pow_m1[IDX_W-1:0];
  end

  // Home slot of the incoming key and the next slot on the probe path.
  assign step_x  = IDX_W'(step_q);
  assign home_in = in_key_i[IDX_W-1:0] & mask;
  assign k_next  = (k_q + step_x) & mask;

  // Read address: home on accept, next slot while probing.
  always_comb begin
    if (cmd_i.accept) begin
      rd_addr = home_in;
    end else if (cmd_i.adv) begin
      rd_addr = k_next;
    end else begin
      rd_addr = k_q;
    end
  end

  // Probe slot and probe count.
  always_comb begin
    k_d   = k_q;
    cnt_d = cnt_q;
    if (cmd_i.accept) begin
      k_d   = home_in;
      cnt_d = '0;
    end else if (cmd_i.adv) begin
      k_d   = k_next;
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    cnt_q <= cnt_d;
    if (cmd_i.accept) begin
      key_q <= in_key_i;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RST;
      step_q <= STEP_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SIZE_LOG2) begin
        size_q <= cfg_data_i[SIZE_W-1:0];
      end
      if (cfg_idx_i == CFG_PROBE_STEP) begin
        step_q <= cfg_data_i[STEP_W-1:0];
      end
    end
  end

  // Clearing sweep address.
  always_comb begin
    clr_addr_d = clr_addr_q;
    if (cmd_i.clr_we) begin
      clr_addr_d = stat_o.clr_last ? '0 : clr_addr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else begin
      clr_addr_q <= clr_addr_d;
    end
  end

  // Used-bit memory: cleared by the sweep, set on insert.
  assign used_we    = cmd_i.ins || cmd_i.clr_we;
  assign used_wd    = cmd_i.ins;
  assign used_waddr = cmd_i.clr_we ? clr_addr_q : k_q;

  ohtab_ram #(
    .WIDTH (1),
    .DEPTH (SLOTS)
  ) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_waddr),
    .wdata_i (used_wd),
    .raddr_i (rd_addr),
    .rdata_o (used_rd)
  );

  // Key memory, written only on insert.
  ohtab_ram #(
    .WIDTH (KEY_W),
    .DEPTH (SLOTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ins),
    .waddr_i (k_q),
    .wdata_i (key_q),
    .raddr_i (rd_addr),
    .rdata_o (key_rd)
  );

  // Status back to the controller.
  assign stat_o.used     = used_rd;
  assign stat_o.hit      = (key_rd == key_q);
  assign stat_o.last     = (cnt_q == IDX_LAST);
  assign stat_o.clr_last = (clr_addr_q == IDX_LAST);

  // Result capture and output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_slot_q   <= cmd_i.res_use_slot ? SLOT_W'(k_q) : '0;
      res_status_q <= cmd_i.res_status;
    end
    if (cmd_i.out_load) begin
      out_slot_q   <= res_slot_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_slot_o   = out_slot_q;
  assign out_status_o = out_status_q;

endmodule

@@ rtl/open_addressing_hash_table_top.sv @@
// ----------------------------------------------------------------------------
// Open-addressing hash table, top level
// Enter and find make P probes, P being 1 to SLOTS; one probe per cycle, set
// by the registered RAM read. The result passes a result register and an
// output register; unknown commands answer without probing, and clear sweeps
// one slot per cycle.
// After reset the used bits are swept with ready low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module open_addressing_hash_table_top #(
  parameter int SLOTS = ohtab_pkg::SLOTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ohtab_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ohtab_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ohtab_in_if.sink                         in_if,
  ohtab_out_if.source                      out_if
);
  import ohtab_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Controller.
  ohtab_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_cmd_i    (in_if.cmd),
    .in_ready_o  (in_if.ready),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  // Datapath.
  ohtab_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_key_i     (in_if.key),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .out_slot_o   (out_if.slot),
    .out_status_o (out_if.status)
  );

endmodule

@@ rtl/ohtab_checker.sv @@
// ----------------------------------------------------------------------------
// Hash table port checker
// Checks result encoding, one-at-a-time command intake and output hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ohtab_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [ohtab_pkg::SLOT_W-1:0]     out_slot_i,
  input logic [ohtab_pkg::STATUS_W-1:0]   out_status_i
);
  import ohtab_pkg::*;

  // Not-found and full results never carry a slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == STAT_NOTFOUND || out_status_i == STAT_FULL)
    |-> out_slot_i == '0)
  else $error("slot is nonzero on a not-found or full result");

  // Ready is low in the cycle after a command beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
  else $error("ready stayed high after a command beat");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i
    |=> out_valid_i && $stable(out_slot_i) && $stable(out_status_i))
  else $error("stalled result changed");

endmodule

bind open_addressing_hash_table_top ohtab_checker u_ohtab_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .out_slot_i   (out_if.slot),
  .out_status_i (out_if.status)
);
